// ===== sv/pts_pkg.sv =====
// shared constants and types for the penrose triangle subdivider
// no dependencies; used by pts_golden_pt and the top level
`default_nettype none

package pts_pkg;

  // round(2^32 / phi), unsigned q0.32
  localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;

  // one half in q0.32, added before the final shift
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

  // robinson triangle kind, carried in tuser
  typedef enum logic {
    KIND_FIRST  = 1'b0,
    KIND_SECOND = 1'b1
  } kind_e;

endpackage : pts_pkg

`default_nettype wire

// ===== sv/pts_golden_pt.sv =====
// five-stage pipeline for one coordinate of the point u + (v - u) / phi
// depends on pts_pkg for the reciprocal constant
`default_nettype none

module pts_golden_pt #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [COORD_WIDTH-1:0] u_i,
  input  wire logic [COORD_WIDTH-1:0] v_i,
  output logic      [COORD_WIDTH-1:0] p_o
);

  localparam int unsigned MW   = COORD_WIDTH + 1;
  localparam int unsigned MAGW = (MW > 32) ? MW : 33;
  localparam int unsigned HW   = MAGW - 32;
  localparam int unsigned RW   = HW + 33;

  // stage 1: exact difference
  logic [MW-1:0]          diff_d, diff_q;
  logic [COORD_WIDTH-1:0] u1_q;
  // stage 2: sign and magnitude
  logic [MW-1:0]          dneg;
  logic [MAGW-1:0]        mag_d, mag_q;
  logic                   neg2_q;
  logic [COORD_WIDTH-1:0] u2_q;
  // stage 3: partial products
  logic [63:0]            plo_q;
  logic [HW+31:0]         phi_q;
  logic                   neg3_q;
  logic [COORD_WIDTH-1:0] u3_q;
  // stage 4: rounded quotient magnitude
  logic [64:0]            rnd;
  logic [RW-1:0]          rsum;
  logic [MW-1:0]          r_q;
  logic                   neg4_q;
  logic [COORD_WIDTH-1:0] u4_q;
  // stage 5: point
  logic [MW-1:0]          uext;
  logic [MW-1:0]          psum;
  logic [COORD_WIDTH-1:0] p_q;

  assign diff_d = {v_i[COORD_WIDTH-1], v_i} - {u_i[COORD_WIDTH-1], u_i};
  assign dneg   = -diff_q;
  assign mag_d  = diff_q[MW-1] ? MAGW'(dneg) : MAGW'(diff_q);
  assign rnd    = {1'b0, plo_q} + {33'd0, pts_pkg::HALF_Q32};
  assign rsum   = RW'(phi_q) + RW'(rnd[64:32]);
  assign uext   = {u4_q[COORD_WIDTH-1], u4_q};
  assign psum   = neg4_q ? (uext - r_q) : (uext + r_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      u1_q   <= u_i;

      mag_q  <= mag_d;
      neg2_q <= diff_q[MW-1];
      u2_q   <= u1_q;

      plo_q  <= mag_q[31:0] * pts_pkg::INV_PHI_Q32;
      phi_q  <= mag_q[MAGW-1:32] * pts_pkg::INV_PHI_Q32;
      neg3_q <= neg2_q;
      u3_q   <= u2_q;

      r_q    <= rsum[MW-1:0];
      neg4_q <= neg3_q;
      u4_q   <= u3_q;

      p_q    <= psum[COORD_WIDTH-1:0];
    end
  end

  assign p_o = p_q;

endmodule : pts_golden_pt

`default_nettype wire

// ===== sv/penrose_triangle_subdivider.sv =====
// penrose triangle subdivider: one robinson triangle in, its children out
// children are sent by the output serialiser, which loads from the last golden-point stage
// throughput is set by the single result channel that serialises the children:
//   two per first-kind triangle, three per second-kind one, stalling the pipe while busy
// reset: asynchronous, active low; clears all valid bits and the child counter
// depends on pts_pkg and pts_golden_pt
`default_nettype none

module penrose_triangle_subdivider #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input triangle stream
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata from bit 0: ax, ay, bx, by, cx, cy, zero pad to whole bytes
  input  wire logic [((6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // tuser: colour
  input  wire logic                 s_axis_tuser_i,
  // child triangle stream
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata from bit 0: ax, ay, bx, by, cx, cy, zero pad to whole bytes
  output logic      [((6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // tuser: colour
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);

  localparam int unsigned TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned STAGES  = 5;
  localparam int unsigned NV      = 6;

  // vertex slots in the packed vertex word
  localparam int unsigned AX = 0;
  localparam int unsigned AY = 1;
  localparam int unsigned BX = 2;
  localparam int unsigned BY = 3;
  localparam int unsigned CX = 4;
  localparam int unsigned CY = 5;

  typedef logic [NV-1:0][COORD_WIDTH-1:0] vtx_t;

  typedef enum logic [1:0] {
    BEAT_FIRST,
    BEAT_SECOND,
    BEAT_THIRD
  } beat_e;

  // ---------------------------------------------------------------------
  // pipeline control: the whole pipe advances together; it stalls only
  // when a finished triangle waits in the last stage and the serialiser
  // is still sending the children of the previous one
  // ---------------------------------------------------------------------
  logic                 pipe_en;
  logic                 emit_free;
  logic                 em_last;
  logic [STAGES-1:0]    vld_q;
  logic                 in_xfer;
  logic                 out_xfer;

  assign pipe_en         = !vld_q[STAGES-1] || emit_free;
  assign s_axis_tready_o = pipe_en;
  assign in_xfer         = s_axis_tvalid_i && pipe_en;

  // ---------------------------------------------------------------------
  // operand selection for the four golden-point units
  // unit 1 gives P (first kind, from A towards B) or Q (second kind,
  // from B towards A); unit 2 gives R (from B towards C)
  // ---------------------------------------------------------------------
  vtx_t                   vtx_in;
  pts_pkg::kind_e         kind_in;
  logic [COORD_WIDTH-1:0] u1x, u1y, v1x, v1y;
  logic [COORD_WIDTH-1:0] p1x, p1y, p2x, p2y;

  assign vtx_in  = s_axis_tdata_i[NV*COORD_WIDTH-1:0];
  assign kind_in = pts_pkg::kind_e'(s_axis_tuser_i);

  always_comb begin
    if (kind_in == pts_pkg::KIND_FIRST) begin
      u1x = vtx_in[AX];
      u1y = vtx_in[AY];
      v1x = vtx_in[BX];
      v1y = vtx_in[BY];
    end else begin
      u1x = vtx_in[BX];
      u1y = vtx_in[BY];
      v1x = vtx_in[AX];
      v1y = vtx_in[AY];
    end
  end

  pts_golden_pt #(.COORD_WIDTH(COORD_WIDTH)) u_pt1x (
    .clk_i, .en_i(pipe_en), .u_i(u1x), .v_i(v1x), .p_o(p1x)
  );
  pts_golden_pt #(.COORD_WIDTH(COORD_WIDTH)) u_pt1y (
    .clk_i, .en_i(pipe_en), .u_i(u1y), .v_i(v1y), .p_o(p1y)
  );
  pts_golden_pt #(.COORD_WIDTH(COORD_WIDTH)) u_pt2x (
    .clk_i, .en_i(pipe_en), .u_i(vtx_in[BX]), .v_i(vtx_in[CX]), .p_o(p2x)
  );
  pts_golden_pt #(.COORD_WIDTH(COORD_WIDTH)) u_pt2y (
    .clk_i, .en_i(pipe_en), .u_i(vtx_in[BY]), .v_i(vtx_in[CY]), .p_o(p2y)
  );

  // ---------------------------------------------------------------------
  // side pipeline: colour and original vertices, aligned with the units
  // ---------------------------------------------------------------------
  vtx_t           vtx_q  [STAGES];
  pts_pkg::kind_e kind_q [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[STAGES-2:0], in_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      vtx_q[0]  <= vtx_in;
      kind_q[0] <= kind_in;
      for (int s = 1; s < STAGES; s++) begin
        vtx_q[s]  <= vtx_q[s-1];
        kind_q[s] <= kind_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output serialiser: holds one finished triangle and its new points,
  // sends two or three children; it reloads on the cycle its last
  // child transfers, so children of consecutive triangles run back to back
  // ---------------------------------------------------------------------
  logic                   em_valid_q;
  beat_e                  beat_q;
  pts_pkg::kind_e         em_kind_q;
  vtx_t                   em_vtx_q;
  logic [COORD_WIDTH-1:0] em_p1x_q, em_p1y_q, em_p2x_q, em_p2y_q;

  assign out_xfer  = em_valid_q && m_axis_tready_i;
  assign em_last   = (em_kind_q == pts_pkg::KIND_FIRST) ? (beat_q == BEAT_SECOND)
                                                        : (beat_q == BEAT_THIRD);
  assign emit_free = !em_valid_q || (m_axis_tready_i && em_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      beat_q     <= BEAT_FIRST;
    end else if (emit_free) begin
      em_valid_q <= vld_q[STAGES-1];
      beat_q     <= BEAT_FIRST;
    end else if (out_xfer) begin
      beat_q <= (beat_q == BEAT_FIRST) ? BEAT_SECOND : BEAT_THIRD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_free && vld_q[STAGES-1]) begin
      em_kind_q <= kind_q[STAGES-1];
      em_vtx_q  <= vtx_q[STAGES-1];
      em_p1x_q  <= p1x;
      em_p1y_q  <= p1y;
      em_p2x_q  <= p2x;
      em_p2y_q  <= p2y;
    end
  end

  // child selection
  // first kind:  (0, C, P, B) then (1, P, C, A)
  // second kind: (1, R, C, A), (1, Q, R, B), then (0, R, Q, A)
  vtx_t           out_vtx;
  pts_pkg::kind_e out_kind;

  always_comb begin
    out_vtx  = em_vtx_q;
    out_kind = pts_pkg::KIND_FIRST;
    if (em_kind_q == pts_pkg::KIND_FIRST) begin
      unique case (beat_q)
        BEAT_FIRST: begin
          out_kind    = pts_pkg::KIND_FIRST;
          out_vtx[AX] = em_vtx_q[CX];
          out_vtx[AY] = em_vtx_q[CY];
          out_vtx[BX] = em_p1x_q;
          out_vtx[BY] = em_p1y_q;
          out_vtx[CX] = em_vtx_q[BX];
          out_vtx[CY] = em_vtx_q[BY];
        end
        default: begin
          out_kind    = pts_pkg::KIND_SECOND;
          out_vtx[AX] = em_p1x_q;
          out_vtx[AY] = em_p1y_q;
          out_vtx[BX] = em_vtx_q[CX];
          out_vtx[BY] = em_vtx_q[CY];
          out_vtx[CX] = em_vtx_q[AX];
          out_vtx[CY] = em_vtx_q[AY];
        end
      endcase
    end else begin
      unique case (beat_q)
        BEAT_FIRST: begin
          out_kind    = pts_pkg::KIND_SECOND;
          out_vtx[AX] = em_p2x_q;
          out_vtx[AY] = em_p2y_q;
          out_vtx[BX] = em_vtx_q[CX];
          out_vtx[BY] = em_vtx_q[CY];
          out_vtx[CX] = em_vtx_q[AX];
          out_vtx[CY] = em_vtx_q[AY];
        end
        BEAT_SECOND: begin
          out_kind    = pts_pkg::KIND_SECOND;
          out_vtx[AX] = em_p1x_q;
          out_vtx[AY] = em_p1y_q;
          out_vtx[BX] = em_p2x_q;
          out_vtx[BY] = em_p2y_q;
          out_vtx[CX] = em_vtx_q[BX];
          out_vtx[CY] = em_vtx_q[BY];
        end
        default: begin
          out_kind    = pts_pkg::KIND_FIRST;
          out_vtx[AX] = em_p2x_q;
          out_vtx[AY] = em_p2y_q;
          out_vtx[BX] = em_p1x_q;
          out_vtx[BY] = em_p1y_q;
          out_vtx[CX] = em_vtx_q[AX];
          out_vtx[CY] = em_vtx_q[AY];
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = em_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(out_vtx);
  assign m_axis_tuser_o  = out_kind;
  assign m_axis_tlast_o  = em_last;

`ifndef SYNTHESIS
  // a first-kind triangle never reaches a third child
  a_first_two_beats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_valid_q && (em_kind_q == pts_pkg::KIND_FIRST) |-> beat_q != BEAT_THIRD)
    else $error("first-kind triangle reached a third child");

  // a stalled pipe keeps its valid bits
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> vld_q == $past(vld_q))
    else $error("valid bits changed during a stall");

  // after the last child with nothing finished behind it, the output goes idle
  a_drain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && em_last && !vld_q[STAGES-1] |=> !m_axis_tvalid_o)
    else $error("output valid without a finished triangle");
`endif

endmodule : penrose_triangle_subdivider

`default_nettype wire
